// File: design/rbsm_pkg.sv
// ---------------------------------------------------------------------------
// rbsm_pkg
// shared widths, register indexes, request flags and back-end states
// ---------------------------------------------------------------------------
`default_nettype none
package rbsm_pkg;

   localparam int TAN_W      = 48;
   localparam int ELEV_W     = 16;
   localparam int ALT_W      = 17;
   localparam int STEP_W     = 24;
   localparam int DELTA_W    = 18;
   localparam int FRAC_SHIFT = 24;
   localparam int NUM_W      = DELTA_W + FRAC_SHIFT;
   localparam int CNT_W      = 6;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_ALT         = 2'd0,
      CSR_RANGE_STEP      = 2'd1,
      CSR_TAN_LOWER_START = 2'd2,
      CSR_TAN_UPPER       = 2'd3
   } csr_index_type;

   // classified request handed from front to back
   typedef struct packed {
      logic signed [DELTA_W-1:0] delta;
      logic                      valid;
      logic                      last;
      logic                      first;
      logic                      rejected;
   } item_flags_type;

   localparam int FLAGS_W = $bits(item_flags_type);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;

endpackage
`default_nettype wire

// File: design/rbsm_front.sv
// ---------------------------------------------------------------------------
// rbsm_front
// accepts requests, forms height delta and divisor, tracks profile distance
// ---------------------------------------------------------------------------
`default_nettype none
module rbsm_front
   import rbsm_pkg::*;
#(
   parameter int     DIST_W   = 36,
   parameter longint DIST_CAP = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic signed [ELEV_W-1:0] elevation,
   input  wire logic                     sample_valid,
   input  wire logic                     last_sample,
   input  wire logic signed [ALT_W-1:0]  ref_alt,
   input  wire logic        [STEP_W-1:0] range_step,
   output      item_flags_type           flags,
   output      logic        [DIST_W-1:0] divisor
);

   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              in_profile_ff, in_profile_in;
   logic [DIST_W-1:0] dist_cur;
   logic [DIST_W:0]   dist_sum;

   // classification of the current request
   always_comb begin
      dist_cur       = in_profile_ff ? dist_ff : '0;
      divisor        = (dist_cur == '0) ? DIST_W'(256) : dist_cur;
      flags.delta    = DELTA_W'(elevation) - DELTA_W'(ref_alt);
      flags.valid    = sample_valid;
      flags.last     = last_sample;
      flags.first    = !in_profile_ff;
      flags.rejected = (range_step == '0) || (!in_profile_ff && last_sample);
   end

   // distance bookkeeping with saturation
   always_comb begin
      dist_sum      = {1'b0, dist_cur} + (DIST_W+1)'(range_step);
      dist_in       = dist_ff;
      in_profile_in = in_profile_ff;
      if (accept) begin
         if (dist_sum > (DIST_W+1)'(DIST_CAP)) dist_in = DIST_W'(DIST_CAP);
         else                                 dist_in = dist_sum[DIST_W-1:0];
         if (last_sample) dist_in = '0;
         in_profile_in = !last_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff       <= '0;
         in_profile_ff <= 1'b0;
      end else begin
         dist_ff       <= dist_in;
         in_profile_ff <= in_profile_in;
      end
   end

endmodule
`default_nettype wire

// File: design/rbsm_queue.sv
// ---------------------------------------------------------------------------
// rbsm_queue
// two-entry queue between the front and back parts
// ---------------------------------------------------------------------------
`default_nettype none
module rbsm_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output      logic              full,
   input  wire logic              pop,
   output      logic [DATA_W-1:0] pop_data,
   output      logic              empty
);

   logic [DATA_W-1:0] mem [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push && !full) mem[wr_ptr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push && !full) wr_ptr_ff <= !wr_ptr_ff;
         if (pop && !empty) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push && !full) - 2'(pop && !empty);
      end
   end

endmodule
`default_nettype wire

// File: design/rbsm_back.sv
// ---------------------------------------------------------------------------
// rbsm_back
// bit-serial tangent divider, beam and shadow test, result register
// ---------------------------------------------------------------------------
`default_nettype none
module rbsm_back
   import rbsm_pkg::*;
#(
   parameter int DIST_W = 36
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_empty,
   input  wire item_flags_type          q_flags,
   input  wire logic       [DIST_W-1:0] q_divisor,
   output      logic                    q_pop,
   input  wire logic signed [TAN_W-1:0] tan_lower_start,
   input  wire logic signed [TAN_W-1:0] tan_upper,
   input  wire logic                    rsp_pop,
   output      logic                    rsp_empty,
   output      logic                    rsp_masked,
   output      logic signed [TAN_W-1:0] rsp_look_tangent,
   output      logic                    rsp_rejected,
   output      logic                    rsp_end_of_profile
);

   back_state_type          state_ff, state_in;
   item_flags_type          flags_ff, flags_in;
   logic [DIST_W-1:0]       div_ff, div_in;
   logic [DIST_W-1:0]       rem_ff, rem_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [TAN_W-1:0] lower_ff, lower_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    masked_ff, masked_in;
   logic signed [TAN_W-1:0] tan_ff, tan_in;
   logic                    rej_ff, rej_in;
   logic                    eop_ff, eop_in;

   logic [DIST_W:0]         rem_t;
   logic                    ge;
   logic [DELTA_W-1:0]      abs_delta;
   logic signed [TAN_W-1:0] tan_c;
   logic signed [TAN_W-1:0] eff_lower;
   logic                    visible;
   logic                    out_free;

   assign rsp_empty          = !out_valid_ff;
   assign rsp_masked         = masked_ff;
   assign rsp_look_tangent   = tan_ff;
   assign rsp_rejected       = rej_ff;
   assign rsp_end_of_profile = eop_ff;

   always_comb begin
      // restoring divide step
      rem_t     = {rem_ff, num_ff[NUM_W-1]};
      ge        = (rem_t >= {1'b0, div_ff});
      abs_delta = q_flags.delta[DELTA_W-1] ? DELTA_W'(-q_flags.delta)
                                           : DELTA_W'(q_flags.delta);
      // signed quotient and visibility test
      tan_c     = flags_ff.delta[DELTA_W-1] ? -TAN_W'(num_ff) : TAN_W'(num_ff);
      eff_lower = flags_ff.first ? tan_lower_start : lower_ff;
      visible   = !flags_ff.rejected && flags_ff.valid
                  && (tan_c >= eff_lower) && (tan_c <= tan_upper);
      out_free  = !out_valid_ff || rsp_pop;

      state_in     = state_ff;
      flags_in     = flags_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      cnt_in       = cnt_ff;
      lower_in     = lower_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      masked_in    = masked_ff;
      tan_in       = tan_ff;
      rej_in       = rej_ff;
      eop_in       = eop_ff;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               flags_in = q_flags;
               div_in   = q_divisor;
               rem_in   = '0;
               num_in   = {abs_delta, {FRAC_SHIFT{1'b0}}};
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = ge ? DIST_W'(rem_t - {1'b0, div_ff}) : rem_t[DIST_W-1:0];
            num_in = {num_ff[NUM_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W-1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               masked_in    = !visible;
               tan_in       = tan_c;
               rej_in       = flags_ff.rejected;
               eop_in       = flags_ff.last;
               lower_in     = visible ? tan_c : eff_lower;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         lower_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         lower_ff     <= lower_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff  <= flags_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      num_ff    <= num_in;
      cnt_ff    <= cnt_in;
      masked_ff <= masked_in;
      tan_ff    <= tan_in;
      rej_ff    <= rej_in;
      eop_ff    <= eop_in;
   end

endmodule
`default_nettype wire

// File: design/radar_beam_shadow_mask_unit.sv
// ---------------------------------------------------------------------------
// radar_beam_shadow_mask_unit
// terrain shadow and beam-edge masking along a radial elevation profile
// ---------------------------------------------------------------------------
// usage:
//   requests (elevation, valid flag, last flag) enter on req_push while
//   req_full is low; one result per request leaves on rsp_* while
//   rsp_empty is low and is taken with rsp_pop.
//   csr_write sets ref_alt, range_step and the two beam-edge tangents;
//   write only while the block is idle.
// data path:
//   the front classifies a request in its accept cycle and queues it in a
//   two-entry queue. the back runs a one-bit-per-cycle restoring divider
//   over the 42-bit scaled height; each item passes load, 42 divide steps
//   and result, and the back takes the next request from the queue only
//   after the result of the last one has entered the output register.
// reset:
//   synchronous, active high; queue and result register empty, registers
//   at their default values, next request starts a profile.
// stall:
//   a result waits in the output register while rsp_pop is low; the back
//   holds its finished item and the queue fills, then req_full rises.
// ---------------------------------------------------------------------------
`default_nettype none
module radar_beam_shadow_mask_unit
   import rbsm_pkg::*;
#(
   parameter int MAX_PROFILE_SAMPLES = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output      logic                     req_full,
   input  wire logic signed [ELEV_W-1:0] req_elevation,
   input  wire logic                     req_sample_valid,
   input  wire logic                     req_last_sample,
   output      logic                     rsp_empty,
   input  wire logic                     rsp_pop,
   output      logic                     rsp_masked,
   output      logic signed [TAN_W-1:0]  rsp_look_tangent,
   output      logic                     rsp_rejected,
   output      logic                     rsp_end_of_profile,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [TAN_W-1:0]         csr_wdata
);

   localparam int  DIST_W   = $clog2(MAX_PROFILE_SAMPLES) + STEP_W;
   localparam longint DIST_CAP_L =
      longint'(MAX_PROFILE_SAMPLES - 1) * ((longint'(1) << STEP_W) - 1);
   localparam int  Q_W      = FLAGS_W + DIST_W;

   logic signed [ALT_W-1:0] ref_alt_ff;
   logic [STEP_W-1:0]       range_step_ff;
   logic signed [TAN_W-1:0] tan_lower_ff;
   logic signed [TAN_W-1:0] tan_upper_ff;

   item_flags_type    f_flags, q_flags;
   logic [DIST_W-1:0] f_div, q_div;
   logic [Q_W-1:0]    q_out;
   logic              accept, q_empty, q_pop;

   assign accept = req_push && !req_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_alt_ff    <= '0;
         range_step_ff <= STEP_W'(25600);
         tan_lower_ff  <= '0;
         tan_upper_ff  <= TAN_W'(65536);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_REF_ALT:         ref_alt_ff    <= csr_wdata[ALT_W-1:0];
            CSR_RANGE_STEP:      range_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_TAN_LOWER_START: tan_lower_ff  <= csr_wdata;
            CSR_TAN_UPPER:       tan_upper_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   rbsm_front #(
      .DIST_W   (DIST_W),
      .DIST_CAP (DIST_CAP_L)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .elevation    (req_elevation),
      .sample_valid (req_sample_valid),
      .last_sample  (req_last_sample),
      .ref_alt      (ref_alt_ff),
      .range_step   (range_step_ff),
      .flags        (f_flags),
      .divisor      (f_div)
   );

   rbsm_queue #(
      .DATA_W (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data ({f_flags, f_div}),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign q_flags = q_out[Q_W-1:DIST_W];
   assign q_div   = q_out[DIST_W-1:0];

   rbsm_back #(
      .DIST_W (DIST_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_flags            (q_flags),
      .q_divisor          (q_div),
      .q_pop              (q_pop),
      .tan_lower_start    (tan_lower_ff),
      .tan_upper          (tan_upper_ff),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_masked         (rsp_masked),
      .rsp_look_tangent   (rsp_look_tangent),
      .rsp_rejected       (rsp_rejected),
      .rsp_end_of_profile (rsp_end_of_profile)
   );

endmodule
`default_nettype wire

// File: design/rbsm_checker.sv
// ---------------------------------------------------------------------------
// rbsm_checker
// port-level checks on the masking unit, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none
module rbsm_checker
   import rbsm_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_full,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire logic             rsp_masked,
   input wire logic [TAN_W-1:0] rsp_look_tangent,
   input wire logic             rsp_rejected
);

   // reset leaves both sides open and no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("reset did not clear queue and result");

   // a stalled result holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_look_tangent)
                                    && $stable(rsp_masked)))
      else $error("result changed while stalled");

   // a rejected sample is always masked
   a_rej_masked: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_rejected) |-> rsp_masked)
      else $error("rejected result not masked");

endmodule

bind radar_beam_shadow_mask_unit rbsm_checker u_rbsm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_masked       (rsp_masked),
   .rsp_look_tangent (rsp_look_tangent),
   .rsp_rejected     (rsp_rejected)
);
`default_nettype wire
